@@ design/ddrp_pkg.sv @@
// ----------------------------------------------------------------------------
// ddrp_pkg: shared types and constants of the differential drive ramp
// Register map, reset values, controller states and the command bundle
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ddrp_pkg;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_RAMP_STEP        = 3'd0;
  localparam logic [2:0] REG_DEAD_OFFSET      = 3'd1;
  localparam logic [2:0] REG_DUTY_PER_PERCENT = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN       = 3'd3;
  localparam logic [2:0] REG_HALF_WHEEL_BASE  = 3'd4;

  localparam logic [14:0] RST_RAMP_STEP        = 15'd256;
  localparam logic [11:0] RST_DEAD_OFFSET      = 12'd20;
  localparam logic [7:0]  RST_DUTY_PER_PERCENT = 8'd40;
  localparam logic [15:0] RST_SPEED_GAIN       = 16'd256;
  localparam logic [15:0] RST_HALF_WHEEL_BASE  = 16'd8192;

  typedef struct packed {
    logic [14:0] ramp_step;
    logic [11:0] dead_offset;
    logic [7:0]  duty_per_percent;
    logic [15:0] speed_gain;
    logic [15:0] half_wheel_base;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANG,
    S_MIX,
    S_RLO,
    S_RHI,
    S_RTGT,
    S_LHI,
    S_LTGT,
    S_RAMP,
    S_DR,
    S_DL,
    S_DONE
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ANG,
    MUL_RLO,
    MUL_RHI,
    MUL_LLO,
    MUL_LHI,
    MUL_DUTY_R,
    MUL_DUTY_L
  } mul_sel_t;

  typedef struct packed {
    logic     latch_in;
    mul_sel_t mul_sel;
    logic     mix_ld;
    logic     acc_ld;
    logic     rtgt_ld;
    logic     ltgt_ld;
    logic     ramp_ld;
    logic     dr_ld;
    logic     out_ld;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/ddrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddrp_ctrl: sequencer of the differential drive ramp
// Steps one word at a time through mixing, ramping and duty computation
// and owns the handshakes of both stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrp_ctrl import ddrp_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  input  wire  in_cmd,
  output logic in_tready,
  output logic out_tvalid,
  input  wire  out_tready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_NONE;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = in_cmd ? S_ANG : S_RAMP;
        end
      end
      S_ANG: begin
        cmd.mul_sel = MUL_ANG;
        state_nxt   = S_MIX;
      end
      S_MIX: begin
        cmd.mix_ld = 1'b1;
        state_nxt  = S_RLO;
      end
      S_RLO: begin
        cmd.mul_sel = MUL_RLO;
        state_nxt   = S_RHI;
      end
      S_RHI: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_sel = MUL_RHI;
        state_nxt   = S_RTGT;
      end
      S_RTGT: begin
        cmd.rtgt_ld = 1'b1;
        cmd.mul_sel = MUL_LLO;
        state_nxt   = S_LHI;
      end
      S_LHI: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_sel = MUL_LHI;
        state_nxt   = S_LTGT;
      end
      S_LTGT: begin
        cmd.ltgt_ld = 1'b1;
        cmd.mul_sel = MUL_DUTY_R;
        state_nxt   = S_DL;
      end
      S_RAMP: begin
        cmd.ramp_ld = 1'b1;
        state_nxt   = S_DR;
      end
      S_DR: begin
        cmd.mul_sel = MUL_DUTY_R;
        state_nxt   = S_DL;
      end
      S_DL: begin
        cmd.dr_ld   = 1'b1;
        cmd.mul_sel = MUL_DUTY_L;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // The result register is free once its word has been taken.
        if (!out_valid_r || out_tready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ design/ddrp_datapath.sv @@
// ----------------------------------------------------------------------------
// ddrp_datapath: arithmetic of the differential drive ramp
// One shared 18x18 signed multiplier with a registered product, the wheel
// speed and target registers, the ramp adders and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrp_datapath import ddrp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        cmd,
  input  cfg_t        cfg,
  input  wire  [15:0] in_linear,
  input  wire  [15:0] in_angular,
  output logic [95:0] out_data
);

  logic [15:0] lin_r, ang_r;
  logic [33:0] mr_r, ml_r;
  logic [35:0] prod_r, acc_r;
  logic [15:0] rcur_r, lcur_r, rtgt_r, ltgt_r;
  logic [15:0] rdp_r, rds_r;
  logic [95:0] out_r;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic [16:0]        rmag, lmag;
  logic [15:0]        tgt_sat;
  logic [15:0]        rnew, lnew;
  logic [15:0]        ldp, lds, rdp, rds;

  function automatic logic [16:0] mag17(input logic [15:0] s);
    logic [16:0] e;
    e = {s[15], s};
    return s[15] ? (17'd0 - e) : e;
  endfunction

  function automatic logic [15:0] ramp_to(input logic [15:0] cur, input logic [15:0] tgt,
                                          input logic [14:0] step);
    logic signed [17:0] c, t, up, dn;
    c  = {{2{cur[15]}}, cur};
    t  = {{2{tgt[15]}}, tgt};
    up = c + $signed({3'b000, step});
    dn = c - $signed({3'b000, step});
    if (c < t) begin
      return (up < t) ? up[15:0] : tgt;
    end else if (c > t) begin
      return (dn > t) ? dn[15:0] : tgt;
    end
    return cur;
  endfunction

  // Scaled magnitude plus dead offset, saturated to 16 bits.
  function automatic logic [15:0] duty_of(input logic [15:0] scaled, input logic [11:0] dead);
    logic [16:0] d;
    d = {1'b0, scaled} + {5'b00000, dead};
    return d[16] ? 16'hFFFF : d[15:0];
  endfunction

  assign rmag = mag17(rcur_r);
  assign lmag = mag17(lcur_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_ANG: begin
        mul_a = {{2{ang_r[15]}}, ang_r};
        mul_b = {2'b00, cfg.half_wheel_base};
      end
      MUL_RLO: begin
        mul_a = {1'b0, mr_r[16:0]};
        mul_b = {2'b00, cfg.speed_gain};
      end
      MUL_RHI: begin
        mul_a = {mr_r[33], mr_r[33:17]};
        mul_b = {2'b00, cfg.speed_gain};
      end
      MUL_LLO: begin
        mul_a = {1'b0, ml_r[16:0]};
        mul_b = {2'b00, cfg.speed_gain};
      end
      MUL_LHI: begin
        mul_a = {ml_r[33], ml_r[33:17]};
        mul_b = {2'b00, cfg.speed_gain};
      end
      MUL_DUTY_R: begin
        mul_a = {1'b0, rmag};
        mul_b = {10'd0, cfg.duty_per_percent};
      end
      MUL_DUTY_L: begin
        mul_a = {1'b0, lmag};
        mul_b = {10'd0, cfg.duty_per_percent};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Target = floor(gain * mix / 2^28): the high partial product sits 17 bits
  // up on the low one, and the arithmetic shift floors toward minus infinity.
  always_comb begin
    logic signed [53:0] hi_ext, lo_ext, sum;
    logic signed [25:0] q;
    hi_ext = $signed({prod_r[35], prod_r, 17'd0});
    lo_ext = $signed({{18{acc_r[35]}}, acc_r});
    sum    = hi_ext + lo_ext;
    q      = sum[53:28];
    if (q > 26'sd32767) begin
      tgt_sat = 16'h7FFF;
    end else if (q < -26'sd32768) begin
      tgt_sat = 16'h8000;
    end else begin
      tgt_sat = q[15:0];
    end
  end

  assign rnew = ramp_to(rcur_r, rtgt_r, cfg.ramp_step);
  assign lnew = ramp_to(lcur_r, ltgt_r, cfg.ramp_step);

  // The product register holds floor(|speed| * duty_per_percent) here.
  always_comb begin
    logic [15:0] d;
    d   = duty_of(prod_r[23:8], cfg.dead_offset);
    rdp = rcur_r[15] ? {4'd0, cfg.dead_offset} : d;
    rds = rcur_r[15] ? d : {4'd0, cfg.dead_offset};
    ldp = lcur_r[15] ? {4'd0, cfg.dead_offset} : d;
    lds = lcur_r[15] ? d : {4'd0, cfg.dead_offset};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcur_r <= '0;
      lcur_r <= '0;
      rtgt_r <= '0;
      ltgt_r <= '0;
    end else begin
      if (cmd.ramp_ld) begin
        rcur_r <= rnew;
        lcur_r <= lnew;
      end
      if (cmd.rtgt_ld) rtgt_r <= tgt_sat;
      if (cmd.ltgt_ld) ltgt_r <= tgt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      lin_r <= in_linear;
      ang_r <= in_angular;
    end
    if (cmd.mul_sel != MUL_NONE) prod_r <= mul_p;
    if (cmd.mix_ld) begin
      mr_r <= {{2{lin_r[15]}}, lin_r, 16'h0000} + prod_r[33:0];
      ml_r <= {{2{lin_r[15]}}, lin_r, 16'h0000} - prod_r[33:0];
    end
    if (cmd.acc_ld) acc_r <= prod_r;
    if (cmd.dr_ld) begin
      rdp_r <= rdp;
      rds_r <= rds;
    end
    if (cmd.out_ld) out_r <= {lds, ldp, rds_r, rdp_r, lcur_r, rcur_r};
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ design/diff_drive_ramp_pwm.sv @@
// ----------------------------------------------------------------------------
// diff_drive_ramp_pwm: two-wheel speed ramp with H-bridge duty output
// Register file and wiring of the controller and the datapath.
// ----------------------------------------------------------------------------
// A word with tuser high sets both wheel targets from a linear and an
// angular speed; a word with tuser low moves each wheel one ramp step toward
// its target. Every word gives one result word with both current speeds and
// the four bridge duty counts. The block takes one word at a time: the next
// word is accepted only after the result of the last one has been loaded
// into the output register. The single shared multiplier serves the mixing
// product, the two gain products per wheel and the two duty products one
// after the other. The next word is taken while a result still waits in the
// output register. Registers are to be written over the APB port only while
// the block is idle; the user is bound to this, the block does not enforce it.
// pready is always high.
`default_nettype none

module diff_drive_ramp_pwm import ddrp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // linear_speed [15:0], angular_speed [31:16]
  input  wire         in_tuser,   // cmd: 0 tick, 1 set polar targets
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,  // right_speed, left_speed, right_duty_primary,
                                  // right_duty_secondary, left_duty_primary,
                                  // left_duty_secondary (16 bits each, low first)
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  cmd_t        cmd;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step        <= RST_RAMP_STEP;
      cfg_r.dead_offset      <= RST_DEAD_OFFSET;
      cfg_r.duty_per_percent <= RST_DUTY_PER_PERCENT;
      cfg_r.speed_gain       <= RST_SPEED_GAIN;
      cfg_r.half_wheel_base  <= RST_HALF_WHEEL_BASE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RAMP_STEP:        cfg_r.ramp_step        <= cfg_pwdata[14:0];
        REG_DEAD_OFFSET:      cfg_r.dead_offset      <= cfg_pwdata[11:0];
        REG_DUTY_PER_PERCENT: cfg_r.duty_per_percent <= cfg_pwdata[7:0];
        REG_SPEED_GAIN:       cfg_r.speed_gain       <= cfg_pwdata[15:0];
        REG_HALF_WHEEL_BASE:  cfg_r.half_wheel_base  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RAMP_STEP:        cfg_prdata = {17'd0, cfg_r.ramp_step};
      REG_DEAD_OFFSET:      cfg_prdata = {20'd0, cfg_r.dead_offset};
      REG_DUTY_PER_PERCENT: cfg_prdata = {24'd0, cfg_r.duty_per_percent};
      REG_SPEED_GAIN:       cfg_prdata = {16'd0, cfg_r.speed_gain};
      REG_HALF_WHEEL_BASE:  cfg_prdata = {16'd0, cfg_r.half_wheel_base};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  ddrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ddrp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .in_linear  (in_tdata[15:0]),
    .in_angular (in_tdata[31:16]),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

@@ design/ddrp_checker.sv @@
// ----------------------------------------------------------------------------
// ddrp_checker: port-level checks of the differential drive ramp
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [95:0] out_tdata,
  input wire        cfg_pready
);

  // A result that is not taken keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The block takes one word at a time, so it drops in_tready after each
  // accepted word.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted word");

  // A stopped wheel drives both bridge halves with the dead offset alone.
  a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:0] == 16'd0) |-> out_tdata[47:32] == out_tdata[63:48])
    else $error("right duties differ at zero speed");

  // The half chosen by a forward left wheel never gets less than the other.
  a_fwd_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[31] && cfg_pready |-> out_tdata[79:64] >= out_tdata[95:80])
    else $error("left primary duty below secondary for forward speed");

endmodule

bind diff_drive_ramp_pwm ddrp_checker u_ddrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
